FILE: rtl/core/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define MTS_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define MTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/mts_pkg.sv
// shared types and codes of the minimum tracking stack
package mts_pkg;

    // operation codes on the request side
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // result status codes
    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

endpackage

FILE: rtl/core/mts_ram.sv
// single write port, single registered read port stack memory
module mts_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 34
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered output
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/min_tracking_stack.sv
// Minimum tracking stack, encoded minimum words held in a synchronous RAM.
// Latency: m_tvalid rises at the clock edge after the accepting one, later while a result waits.
// s_tready is low from accept until the result is registered: every request passes ST_READ,
// where a pop takes the new top word from the RAM read (top word is cached in a register).
// Reset (aresetn low, synchronous) empties the stack and clears the minimum;
// RAM contents are not cleared and need no clearing pass.
`include "assert_macros.svh"

module min_tracking_stack
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // value
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    // func
    input  logic [0:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // removed_value, top_value, minimum, is_empty, count
    output logic [((3*VALUE_WIDTH+1+$clog2(STACK_DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // status
    output logic [1:0]  m_tuser
);

    localparam int VW     = VALUE_WIDTH;
    localparam int WW     = VALUE_WIDTH + 2;
    localparam int AW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW     = $clog2(STACK_DEPTH + 1);
    localparam int OUT_B  = 3 * VW + 1 + CW;
    localparam int OUT_DW = ((OUT_B + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic signed [VW-1:0]     min_reg, min_next;
    logic signed [WW-1:0]     top_word_reg, top_word_next;
    logic                     need_read_reg, need_read_next;
    status_t                  status_reg, status_next;
    logic signed [VW-1:0]     removed_reg, removed_next;
    logic                     m_valid_reg, m_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic signed [VW-1:0]     out_removed_reg, out_removed_next;
    logic signed [VW-1:0]     out_top_reg, out_top_next;
    logic signed [VW-1:0]     out_min_reg, out_min_next;
    logic                     out_empty_reg, out_empty_next;
    logic [CW-1:0]            out_count_reg, out_count_next;

    logic                     s_accept;
    logic                     out_free;
    logic                     in_func;
    logic signed [VW-1:0]     in_value;
    logic signed [WW-1:0]     x_w, min_w, enc_word, eff_word, restored;
    logic                     is_empty_now, is_full_now;
    logic [CW-1:0]            count_m2;

    logic                     ram_wr_en;
    logic [AW-1:0]            ram_wr_addr;
    logic signed [WW-1:0]     ram_wr_data;
    logic                     ram_rd_en;
    logic [AW-1:0]            ram_rd_addr;
    logic [WW-1:0]            ram_rd_data;

    // stack word storage
    mts_ram #(
        .ADDR_W (AW),
        .DATA_W (WW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // request unpacking and handshake
    assign in_func  = s_tuser[0];
    assign in_value = s_tdata[VW-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // widened operands for the encoded minimum arithmetic
    assign x_w          = {{2{in_value[VW-1]}}, in_value};
    assign min_w        = {{2{min_reg[VW-1]}}, min_reg};
    assign enc_word     = (x_w <<< 1) - min_w;
    assign restored     = (min_w <<< 1) - top_word_reg;
    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg == CW'(STACK_DEPTH));
    assign count_m2     = count_reg - CW'(2);

    // word under the top after a pop arrives from the ram in the read cycle
    assign eff_word = need_read_reg ? $signed(ram_rd_data) : top_word_reg;

    // ram accesses, issued in the accept cycle
    always_comb begin
        ram_wr_en   = s_accept && (in_func == FUNC_PUSH) && !is_full_now;
        ram_wr_addr = count_reg[AW-1:0];
        ram_wr_data = (is_empty_now || (x_w >= min_w)) ? x_w : enc_word;
        ram_rd_en   = s_accept && (in_func == FUNC_POP) && (count_reg > CW'(1));
        ram_rd_addr = count_m2[AW-1:0];
    end

    // sequencer and result formation
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        min_next         = min_reg;
        top_word_next    = top_word_reg;
        need_read_next   = need_read_reg;
        status_next      = status_reg;
        removed_next     = removed_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_removed_next = out_removed_reg;
        out_top_next     = out_top_reg;
        out_min_next     = out_min_reg;
        out_empty_next   = out_empty_reg;
        out_count_next   = out_count_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    status_next    = STATUS_OK;
                    removed_next   = '0;
                    need_read_next = 1'b0;
                    state_next     = ST_READ;
                    if (in_func == FUNC_PUSH) begin
                        if (is_full_now) begin
                            status_next = STATUS_FULL;
                        end else begin
                            top_word_next = ram_wr_data;
                            count_next    = count_reg + CW'(1);
                            if (is_empty_now || (x_w < min_w)) begin
                                min_next = in_value;
                            end
                        end
                    end else begin
                        if (is_empty_now) begin
                            status_next = STATUS_EMPTY;
                        end else begin
                            // encoded word below the minimum marks a minimum change
                            if (top_word_reg >= min_w) begin
                                removed_next = top_word_reg[VW-1:0];
                            end else begin
                                removed_next = min_reg;
                                min_next     = restored[VW-1:0];
                            end
                            count_next     = count_reg - CW'(1);
                            need_read_next = (count_reg > CW'(1));
                        end
                    end
                end
            end
            ST_READ, ST_WAIT: begin
                top_word_next  = eff_word;
                need_read_next = 1'b0;
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    out_status_next  = status_reg;
                    out_removed_next = removed_reg;
                    out_count_next   = count_reg;
                    out_empty_next   = is_empty_now;
                    if (is_empty_now) begin
                        out_top_next = '0;
                        out_min_next = '0;
                    end else begin
                        out_top_next = (eff_word >= min_w) ? eff_word[VW-1:0] : min_reg;
                        out_min_next = min_reg;
                    end
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_WAIT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            min_reg       <= '0;
            need_read_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            min_reg       <= min_next;
            need_read_reg <= need_read_next;
            m_valid_reg   <= m_valid_next;
        end
        top_word_reg    <= top_word_next;
        status_reg      <= status_next;
        removed_reg     <= removed_next;
        out_status_reg  <= out_status_next;
        out_removed_reg <= out_removed_next;
        out_top_reg     <= out_top_next;
        out_min_reg     <= out_min_next;
        out_empty_reg   <= out_empty_next;
        out_count_reg   <= out_count_next;
    end

    // result packing
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = OUT_DW'({out_count_reg, out_empty_reg, out_min_reg,
                               out_top_reg, out_removed_reg});

    // checks
    `MTS_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CW'(STACK_DEPTH))
    `MTS_ASSERT_ALWAYS(a_empty_flag, aclk, aresetn,
                       !m_valid_reg || (out_empty_reg == (out_count_reg == '0)))
    `MTS_ASSERT_NEXT(a_count_step, aclk, aresetn, s_accept,
                     (count_reg == $past(count_reg)) ||
                     (count_reg == $past(count_reg) + CW'(1)) ||
                     (count_reg == $past(count_reg) - CW'(1)))
    `MTS_ASSERT_NEXT(a_count_hold, aclk, aresetn, !s_accept, $stable(count_reg))

endmodule
